### rtl/rsus_pkg.sv
// Package for the range smallest-unreachable-sum block.
// Holds sizes, request and status codes and the beat payload types. No dependencies.
package rsus_pkg;
	localparam int MAX_ELEMENTS_D = 1024;
	localparam int VALUE_BITS_D = 30;
	localparam int NODE_POOL_D = 32768;
	localparam int VW = 30;
	localparam int IW = 11;
	localparam int AW = 41;
	localparam int SW = 40;
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;
	typedef struct packed {
		logic req_type;
		logic [VW-1:0] element_value;
		logic [IW-1:0] range_left;
		logic [IW-1:0] range_right;
	} req_t;
	typedef struct packed {
		logic [AW-1:0] answer;
		logic [1:0] status;
	} rsp_t;
endpackage

### rtl/rsus_if.sv
// Valid/ready channel interface carrying one beat of payload type T.
// Depends on rsus_pkg for the payload types used by the top level.
interface rsus_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/range_smallest_unreachable_sum_top.sv
// Top level of the range smallest-unreachable-sum block: node pool memories and sequencer.
// Depends on rsus_pkg and rsus_if.
//
// Use: requests arrive as beats on req (append or query); each request yields
// exactly one beat on rsp with answer and status. An append walks one
// root-to-leaf path of up to VALUE_BITS+1 nodes, each node read from the
// registered node memory and then written anew. A query runs rounds of
// prefix walks; each round reads up to VALUE_BITS+1 levels, the nodes of two
// versions and their left children in turn through the shared read port.
// Only one request is in flight; req is ready while the sequencer is idle
// and the result register is free or being taken. A stalled rsp holds the
// result and the sequencer waits for it. Reset clears the node and element
// counts and treats node 0 and version 0 as the empty tree; no clearing pass
// runs.
module range_smallest_unreachable_sum_top
	import rsus_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_D,
	parameter int VALUE_BITS = VALUE_BITS_D,
	parameter int NODE_POOL = NODE_POOL_D
) (
	input logic clk,
	input logic arst_n,
	rsus_if.sink req,
	rsus_if.source rsp
);
	localparam int NB = $clog2(NODE_POOL);
	localparam int EB = $clog2(MAX_ELEMENTS + 1);
	localparam logic [VW:0] VMAX = (VW+1)'((64'd1 << VALUE_BITS) - 64'd1);
	localparam logic [5:0] PLEN = 6'(VALUE_BITS + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_AROOT = 4'd1, S_AREAD = 4'd2,
		S_AWR = 4'd3, S_QROOTU = 4'd4, S_QROOTV = 4'd5, S_RU = 4'd6,
		S_RV = 4'd7, S_LU = 4'd8, S_LV = 4'd9, S_STEP = 4'd10,
		S_ROUND = 4'd11, S_OUT = 4'd12;

	typedef struct packed {
		logic [NB-1:0] lc;
		logic [NB-1:0] rc;
		logic [SW-1:0] sm;
	} node_t;

	node_t node_mem [NODE_POOL];
	logic [NB-1:0] root_mem [MAX_ELEMENTS+1];

	logic [3:0] state_q;
	logic [NB-1:0] node_cnt_q;
	logic [EB-1:0] elem_cnt_q;
	logic [VW:0] lo_q, hi_q, x_q, y_q;
	logic [NB-1:0] u_q, v_q, prev_q, root_q, ru_q, rv_q;
	logic [SW-1:0] acc_q, su_q;
	node_t nu_q, nv_q;
	logic [AW-1:0] ans_q;
	logic [IW-1:0] l_q, r_q;

	logic [NB-1:0] n_raddr;
	logic n_re;
	node_t n_rdata, n_wdata;
	logic [NB-1:0] n_waddr;
	logic n_we;
	logic [EB-1:0] r_raddr, r_waddr;
	logic [NB-1:0] r_rdata, r_wdata;
	logic r_we;
	logic rz_q;

	always_ff @(posedge clk) begin
		if (n_we) node_mem[n_waddr] <= n_wdata;
		if (n_re) n_rdata <= node_mem[n_raddr];
		if (r_we) root_mem[r_waddr] <= r_wdata;
		r_rdata <= root_mem[r_raddr];
		rz_q <= r_raddr == '0;
	end

	logic out_v_q;
	rsp_t out_q;
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;
	assign req.ready = (state_q == S_IDLE) && (!out_v_q || rsp.ready);

	logic [VW:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	node_t rd;
	// Node 0 and version 0 read as the empty tree.
	logic zero_n;
	assign rd = zero_n ? '0 : n_rdata;
	logic zr_q;
	assign zero_n = zr_q;
	logic [NB-1:0] rt;
	assign rt = rz_q ? '0 : r_rdata;

	logic [5:0] plen;
	assign plen = ({1'b0, req.data.element_value} == VMAX) ? PLEN - 6'd1 : PLEN;
	logic [NB:0] need_n;
	assign need_n = (NB+1)'(node_cnt_q) + (NB+1)'(plen);

	always_comb begin
		n_re = 1'b0;
		n_raddr = '0;
		n_we = 1'b0;
		n_waddr = '0;
		n_wdata = '0;
		r_raddr = '0;
		r_we = 1'b0;
		r_waddr = '0;
		r_wdata = '0;
		case (state_q)
			S_IDLE: begin
				r_raddr = req.data.req_type == REQ_QUERY ?
					EB'(req.data.range_left - 1'b1) : elem_cnt_q;
			end
			S_QROOTU: r_raddr = EB'(r_q);
			S_AREAD: begin
				n_re = 1'b1;
				n_raddr = prev_q;
			end
			S_RU, S_RV, S_LU, S_LV: begin
				n_re = 1'b1;
				n_raddr = (state_q == S_RU) ? u_q : (state_q == S_RV) ? v_q :
					(state_q == S_LU) ? nu_q.lc : nv_q.lc;
			end
			S_AWR: begin
				n_we = 1'b1;
				n_waddr = node_cnt_q + 1'b1;
				n_wdata.lc = rd.lc;
				n_wdata.rc = rd.rc;
				n_wdata.sm = rd.sm + SW'(x_q);
				if (lo_q < hi_q) begin
					if (x_q <= mid) n_wdata.lc = node_cnt_q + 2'd2;
					else n_wdata.rc = node_cnt_q + 2'd2;
				end
				if (lo_q >= hi_q) begin
					r_we = 1'b1;
					r_waddr = elem_cnt_q + 1'b1;
					r_wdata = root_q;
				end
			end
			default: ;
		endcase
	end

	logic [VW:0] lim;
	assign lim = (ans_q < AW'(VMAX)) ? (VW+1)'(ans_q) : VMAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			node_cnt_q <= '0;
			elem_cnt_q <= '0;
			out_v_q <= 1'b0;
			zr_q <= 1'b0;
		end else begin
			if (state_q == S_OUT) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					x_q <= {1'b0, req.data.element_value};
					l_q <= req.data.range_left;
					r_q <= req.data.range_right;
					if (req.data.req_type == REQ_APPEND) begin
						if (req.data.element_value == '0 ||
							{1'b0, req.data.element_value} > VMAX) begin
							out_q <= '{answer: '0, status: ST_BAD};
							state_q <= S_OUT;
						end else if (32'(elem_cnt_q) >= MAX_ELEMENTS ||
							32'(need_n) > NODE_POOL - 1) begin
							out_q <= '{answer: '0, status: ST_FULL};
							state_q <= S_OUT;
						end else begin
							state_q <= S_AROOT;
						end
					end else begin
						if (req.data.range_left == '0 ||
							32'(req.data.range_right) > 32'(elem_cnt_q) ||
							req.data.range_left > req.data.range_right) begin
							out_q <= '{answer: '0, status: ST_BAD};
							state_q <= S_OUT;
						end else begin
							state_q <= S_QROOTU;
						end
					end
				end
				S_AROOT: begin
					prev_q <= rt;
					lo_q <= (VW+1)'(1);
					hi_q <= VMAX;
					root_q <= node_cnt_q + 1'b1;
					state_q <= S_AREAD;
				end
				S_AREAD: begin
					zr_q <= prev_q == '0;
					state_q <= S_AWR;
				end
				S_AWR: begin
					node_cnt_q <= node_cnt_q + 1'b1;
					if (lo_q >= hi_q) begin
						elem_cnt_q <= elem_cnt_q + 1'b1;
						out_q <= '{answer: '0, status: ST_OK};
						state_q <= S_OUT;
					end else begin
						if (x_q <= mid) begin
							prev_q <= rd.lc;
							hi_q <= mid;
						end else begin
							prev_q <= rd.rc;
							lo_q <= mid + 1'b1;
						end
						state_q <= S_AREAD;
					end
				end
				S_QROOTU: begin
					ru_q <= rt;
					ans_q <= AW'(1);
					state_q <= S_QROOTV;
				end
				S_QROOTV: begin
					rv_q <= rt;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					lo_q <= (VW+1)'(1);
					hi_q <= VMAX;
					acc_q <= '0;
					y_q <= lim;
					u_q <= ru_q;
					v_q <= rv_q;
					state_q <= S_RU;
				end
				S_RU: begin
					zr_q <= u_q == '0;
					state_q <= S_RV;
				end
				S_RV: begin
					nu_q <= rd;
					zr_q <= v_q == '0;
					state_q <= S_LU;
				end
				S_LU: begin
					nv_q <= rd;
					zr_q <= nu_q.lc == '0;
					state_q <= S_LV;
				end
				S_LV: begin
					su_q <= rd.sm;
					zr_q <= nv_q.lc == '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (y_q >= hi_q || lo_q >= hi_q) begin
						logic [SW-1:0] s;
						s = (y_q >= hi_q) ? acc_q + (nv_q.sm - nu_q.sm) : acc_q;
						if (AW'(s) >= ans_q) begin
							ans_q <= AW'(s) + 1'b1;
							state_q <= S_ROUND;
						end else begin
							out_q <= '{answer: ans_q, status: ST_OK};
							state_q <= S_OUT;
						end
					end else if (y_q > mid) begin
						acc_q <= acc_q + (rd.sm - su_q);
						u_q <= nu_q.rc;
						v_q <= nv_q.rc;
						lo_q <= mid + 1'b1;
						state_q <= S_RU;
					end else begin
						u_q <= nu_q.lc;
						v_q <= nv_q.lc;
						hi_q <= mid;
						state_q <= S_RU;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/rsus_checker.sv
// Port-level checker for the range smallest-unreachable-sum block, with its bind.
// Depends on rsus_pkg and the top level's ports.
module rsus_checker
	import rsus_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.answer == '0)
		else $error("error with answer");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("two in flight");
endmodule

bind range_smallest_unreachable_sum_top rsus_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

### test/range_smallest_unreachable_sum_top_tb.sv
// Testbench for range_smallest_unreachable_sum_top: appends and range queries checked beat by beat
// against a predictor of the persistent sum tree. Depends on rsus_pkg and rsus_if.
`timescale 1ns / 1ps

module range_smallest_unreachable_sum_top_tb;
	import rsus_pkg::*;

	localparam longint unsigned VMAX = (64'd1 << VALUE_BITS_D) - 1;
	localparam int LIMIT_CYCLES = 20000000;
	localparam int TAIL_CYCLES = 400;

	logic clk;
	logic arst_n;
	rsus_if #(.T(req_t)) req ();
	rsus_if #(.T(rsp_t)) rsp ();

	range_smallest_unreachable_sum_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic [14:0] tree_left [NODE_POOL_D];
	logic [14:0] tree_right [NODE_POOL_D];
	logic [39:0] tree_sum [NODE_POOL_D];
	logic [14:0] root_of [MAX_ELEMENTS_D + 1];
	int unsigned nodes_used;
	int unsigned elems_held;

	rsp_t pending_rsp [$];
	int errors;
	int cycles;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned path_nodes(longint unsigned x);
		longint unsigned lo, hi, mid;
		int unsigned n;
		lo = 1;
		hi = VMAX;
		n = 1;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (x <= mid) hi = mid;
			else lo = mid + 1;
			n++;
		end
		return n;
	endfunction

	function automatic logic [14:0] grow_path(logic [14:0] prev, longint unsigned x);
		longint unsigned lo, hi, mid;
		logic [14:0] root, parent, o;
		bit to_left;
		lo = 1;
		hi = VMAX;
		root = 0;
		parent = 0;
		to_left = 0;
		forever begin
			nodes_used++;
			o = nodes_used[14:0];
			tree_left[o] = tree_left[prev];
			tree_right[o] = tree_right[prev];
			tree_sum[o] = tree_sum[prev] + x;
			if (root == 0) root = o;
			else if (to_left) tree_left[parent] = o;
			else tree_right[parent] = o;
			if (lo >= hi) break;
			mid = lo + (hi - lo) / 2;
			parent = o;
			if (x <= mid) begin
				to_left = 1;
				prev = tree_left[prev];
				hi = mid;
			end else begin
				to_left = 0;
				prev = tree_right[prev];
				lo = mid + 1;
			end
		end
		return root;
	endfunction

	function automatic longint unsigned range_sum_upto(logic [14:0] u, logic [14:0] v,
			longint unsigned y);
		longint unsigned lo, hi, mid, acc;
		lo = 1;
		hi = VMAX;
		acc = 0;
		forever begin
			if (y >= hi) return acc + (tree_sum[v] - tree_sum[u]);
			if (lo >= hi) return acc;
			mid = lo + (hi - lo) / 2;
			if (y > mid) begin
				acc += tree_sum[tree_left[v]] - tree_sum[tree_left[u]];
				u = tree_right[u];
				v = tree_right[v];
				lo = mid + 1;
			end else begin
				u = tree_left[u];
				v = tree_left[v];
				hi = mid;
			end
		end
	endfunction

	function automatic rsp_t predict_reply(req_t r);
		rsp_t o;
		longint unsigned x, ans, lim, s, l, rr;
		logic [14:0] u, v;
		o.answer = '0;
		o.status = ST_OK;
		if (r.req_type == REQ_APPEND) begin
			x = r.element_value;
			if (x == 0 || x > VMAX) begin
				o.status = ST_BAD;
			end else if (elems_held >= MAX_ELEMENTS_D ||
					nodes_used + path_nodes(x) > NODE_POOL_D - 1) begin
				o.status = ST_FULL;
			end else begin
				u = grow_path(root_of[elems_held], x);
				elems_held++;
				root_of[elems_held] = u;
			end
		end else begin
			l = r.range_left;
			rr = r.range_right;
			if (l == 0 || rr > elems_held || l > rr) begin
				o.status = ST_BAD;
			end else begin
				u = root_of[l - 1];
				v = root_of[rr];
				ans = 1;
				forever begin
					lim = (ans < VMAX) ? ans : VMAX;
					s = range_sum_upto(u, v, lim);
					if (s >= ans) ans = s + 1;
					else break;
				end
				o.answer = ans[AW-1:0];
			end
		end
		return o;
	endfunction

	task automatic send_req(req_t r);
		int gap;
		if (!calm && $urandom_range(99) < 38) begin
			req.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		pending_rsp.push_back(predict_reply(r));
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_append(longint unsigned val);
		req_t r;
		r.req_type = REQ_APPEND;
		r.element_value = val[VW-1:0];
		r.range_left = IW'($urandom);
		r.range_right = IW'($urandom);
		send_req(r);
	endtask

	task automatic send_query(int unsigned l, int unsigned rr);
		req_t r;
		r.req_type = REQ_QUERY;
		r.element_value = VW'($urandom);
		r.range_left = l[IW-1:0];
		r.range_right = rr[IW-1:0];
		send_req(r);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected beat answer=%0d status=%0d", $time,
					rsp.data.answer, rsp.data.status);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.data.answer !== want.answer) begin
					$display("%0t: answer expected %0d actual %0d", $time,
						want.answer, rsp.data.answer);
					errors++;
				end
				if (rsp.data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp.data.status);
					errors++;
				end
			end
		end
		rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
	end

	task automatic test_directed();
		send_append(0);
		send_query(1, 1);
		send_query(0, 0);
		send_append(1);
		send_query(1, 1);
		send_append(VMAX);
		send_append(2);
		send_append(1);
		send_query(1, 4);
		send_query(2, 3);
		send_query(3, 2);
		send_query(0, 4);
		send_query(1, 5);
		send_query(2047, 2047);
		send_query(1024, 1024);
		send_append(64'h3FFF_FFFF);
		send_append(4);
		send_query(4, 6);
		send_query(6, 6);
		send_query(1, 6);
		drain();
	endtask

	task automatic test_powers();
		for (int i = 0; i < VALUE_BITS_D; i++) send_append(64'd1 << i);
		send_append(1);
		send_query(elems_held - VALUE_BITS_D, elems_held);
		send_query(1, elems_held);
		drain();
	endtask

	task automatic test_paced();
		for (int i = 0; i < 6; i++) begin
			if (i % 2 == 0) send_append($urandom_range(1, 5));
			else send_query(1, elems_held);
			drain();
		end
	endtask

	task automatic random_item();
		int unsigned k, l, rr;
		k = $urandom_range(99);
		if (k < 40) begin
			if ($urandom_range(2) == 0) send_append($urandom_range(1, 8));
			else if ($urandom_range(3) == 0) send_append(VMAX);
			else send_append($urandom_range(1, VMAX));
		end else if (k < 85) begin
			l = $urandom_range(1, elems_held);
			rr = $urandom_range(l, elems_held);
			send_query(l, rr);
		end else if (k < 92) begin
			send_query($urandom & 11'h7FF, $urandom & 11'h7FF);
		end else begin
			send_append(0);
		end
	endtask

	task automatic test_random();
		for (int i = 0; i < 120; i++) random_item();
		calm = 1;
		for (int i = 0; i < 40; i++) random_item();
		calm = 0;
		for (int i = 0; i < 70; i++) random_item();
		drain();
	endtask

	task automatic test_bounds();
		send_append(5);
		send_append(0);
		send_append(VMAX);
		send_query(1, 1024);
		send_query(1, elems_held);
		send_query(1, 1025);
		send_query(2047, 1024);
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		calm = 0;
		nodes_used = 0;
		elems_held = 0;
		for (int i = 0; i < NODE_POOL_D; i++) begin
			tree_left[i] = '0;
			tree_right[i] = '0;
			tree_sum[i] = '0;
		end
		for (int i = 0; i <= MAX_ELEMENTS_D; i++) root_of[i] = '0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_powers();
		test_paced();
		test_random();
		test_bounds();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/rsus_pkg.sv
rtl/rsus_if.sv
rtl/range_smallest_unreachable_sum_top.sv
rtl/rsus_checker.sv
test/range_smallest_unreachable_sum_top_tb.sv
